// File: src/twr_pkg.sv
// Package for the windowed TFTP receiver.
// Holds the item and result types, opcodes, status codes and round trip weights.
// No dependencies.
package twr_pkg;

  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ERROR = 16'd5;
  localparam logic [15:0] HDR_BYTES = 16'd4;

  localparam logic [1:0] ST_RUNNING  = 2'd0;
  localparam logic [1:0] ST_FINISHED = 2'd1;
  localparam logic [1:0] ST_PEER_ERR = 2'd2;
  localparam logic [1:0] ST_OVERSIZE = 2'd3;

  localparam logic [1:0] CFG_BLOCK_SIZE  = 2'd0;
  localparam logic [1:0] CFG_WINDOW_SIZE = 2'd1;
  localparam logic [1:0] CFG_ROLLOVER    = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd3;

  localparam logic [15:0] RST_BLOCK_SIZE  = 16'd512;
  localparam logic [15:0] RST_WINDOW_SIZE = 16'd1;
  localparam logic        RST_ROLLOVER    = 1'b0;
  localparam logic [31:0] RST_TIMEOUT     = 32'd1000000;

  localparam logic KIND_PACKET  = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  // The weight scale is a power of two, so the average is a shift.
  localparam int RTT_KEEP_WEIGHT = 7;
  localparam int RTT_SCALE_LOG2  = 3;
  localparam int RTT_WEIGHT_SCALE = 1 << RTT_SCALE_LOG2;
  localparam int RTT_FRESH_WEIGHT =
      (RTT_WEIGHT_SCALE > RTT_KEEP_WEIGHT) ? (RTT_WEIGHT_SCALE - RTT_KEEP_WEIGHT) : 0;
  localparam int RTT_ACC_W = 32 + 5 + 1;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic [15:0] opcode;
    logic [15:0] block_number;
    logic [15:0] packet_length;
    logic [31:0] now_us;
  } event_t;

  typedef struct packed {
    logic        accept_data;
    logic [15:0] payload_bytes;
    logic        send_ack;
    logic [15:0] ack_block;
    logic        restart_wait;
    logic [1:0]  status;
    logic [47:0] total_bytes;
    logic [31:0] round_trip_us;
  } result_t;

endpackage

// File: src/twr_in_reg.sv
// Input register of the windowed TFTP receiver.
// Holds one accepted item until the decision stage takes it. Uses twr_pkg.
module twr_in_reg import twr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  event_t in_item,
  output logic   held_valid,
  output event_t held_item,
  input  logic   take
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// File: src/twr_step.sv
// Decision stage of the windowed TFTP receiver.
// Holds the configuration and transfer state and computes one result per item.
// Uses twr_pkg.
module twr_step import twr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        fire,
  input  event_t      ev,
  output result_t     res
);

  logic [15:0] block_size;
  logic [15:0] window_size;
  logic        rollover_block;
  logic [15:0] expected_block;
  logic [15:0] last_received_block;
  logic [15:0] last_acked_block;
  logic [15:0] window_count;
  logic [47:0] byte_total;
  logic [31:0] rtt_estimate;
  logic [31:0] ack_sent_time;
  logic        wait_active;
  logic        finished;

  logic [15:0] expected_block_next;
  logic [15:0] last_received_block_next;
  logic [15:0] last_acked_block_next;
  logic [15:0] window_count_next;
  logic [47:0] byte_total_next;
  logic [31:0] rtt_estimate_next;
  logic [31:0] ack_sent_time_next;
  logic        wait_active_next;
  logic        finished_next;

  logic [15:0] payload;
  logic [48:0] sum_total;
  logic [15:0] wc_inc;
  logic        is_final;
  logic [31:0] sample;
  logic [RTT_ACC_W-1:0] acc;
  logic [RTT_ACC_W-1:0] avg;
  logic [31:0] rtt_avg;

  assign payload   = ev.packet_length - HDR_BYTES;
  assign sum_total = {1'b0, byte_total} + {33'd0, payload};
  assign wc_inc    = window_count + 16'd1;
  assign is_final  = payload != block_size;
  assign sample    = ev.now_us - ack_sent_time;
  assign acc = ({{(RTT_ACC_W-32){1'b0}}, rtt_estimate} * RTT_ACC_W'(RTT_KEEP_WEIGHT))
             + ({{(RTT_ACC_W-32){1'b0}}, sample} * RTT_ACC_W'(RTT_FRESH_WEIGHT));
  assign avg = acc >> RTT_SCALE_LOG2;
  assign rtt_avg = (avg > RTT_ACC_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : avg[31:0];

  always_comb begin
    expected_block_next      = expected_block;
    last_received_block_next = last_received_block;
    last_acked_block_next    = last_acked_block;
    window_count_next        = window_count;
    byte_total_next          = byte_total;
    rtt_estimate_next        = rtt_estimate;
    ack_sent_time_next       = ack_sent_time;
    wait_active_next         = wait_active;
    finished_next            = finished;
    res.accept_data   = 1'b0;
    res.payload_bytes = 16'd0;
    res.send_ack      = 1'b0;
    res.ack_block     = 16'd0;
    res.restart_wait  = 1'b0;
    res.status        = ST_RUNNING;
    if (finished) begin
      res.status = ST_RUNNING;
    end else if (ev.kind == KIND_TIMEOUT) begin
      res.send_ack       = 1'b1;
      res.ack_block      = last_acked_block;
      res.restart_wait   = 1'b1;
      ack_sent_time_next = ev.now_us;
      wait_active_next   = 1'b1;
    end else if (ev.packet_length < HDR_BYTES) begin
      res.status = ST_RUNNING;
    end else if (ev.opcode == OP_ERROR) begin
      res.status    = ST_PEER_ERR;
      finished_next = 1'b1;
    end else if (ev.opcode != OP_DATA) begin
      res.status = ST_RUNNING;
    end else if (ev.block_number != expected_block) begin
      res.send_ack  = 1'b1;
      res.ack_block = last_received_block;
    end else if (payload > block_size) begin
      res.status    = ST_OVERSIZE;
      finished_next = 1'b1;
    end else begin
      res.accept_data   = 1'b1;
      res.payload_bytes = payload;
      byte_total_next   = sum_total[48] ? MAX48 : sum_total[47:0];
      window_count_next = wc_inc;
      last_received_block_next = ev.block_number;
      expected_block_next = (expected_block == 16'hFFFF) ? {15'd0, rollover_block}
                                                         : expected_block + 16'd1;
      if (is_final || wc_inc == window_size) begin
        if (wait_active && ev.now_us >= ack_sent_time) begin
          rtt_estimate_next = rtt_avg;
        end
        last_acked_block_next = ev.block_number;
        window_count_next     = 16'd0;
        res.send_ack          = 1'b1;
        res.ack_block         = ev.block_number;
        res.restart_wait      = 1'b1;
        ack_sent_time_next    = ev.now_us;
        wait_active_next      = 1'b1;
        if (is_final) begin
          res.status    = ST_FINISHED;
          finished_next = 1'b1;
        end
      end
    end
    res.total_bytes   = byte_total_next;
    res.round_trip_us = rtt_estimate_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size          <= RST_BLOCK_SIZE;
      window_size         <= RST_WINDOW_SIZE;
      rollover_block      <= RST_ROLLOVER;
      expected_block      <= 16'd1;
      last_received_block <= 16'd0;
      last_acked_block    <= 16'd0;
      window_count        <= 16'd0;
      byte_total          <= 48'd0;
      rtt_estimate        <= RST_TIMEOUT;
      ack_sent_time       <= 32'd0;
      wait_active         <= 1'b0;
      finished            <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BLOCK_SIZE:  block_size     <= cfg_data[15:0];
        CFG_WINDOW_SIZE: window_size    <= cfg_data[15:0];
        CFG_ROLLOVER:    rollover_block <= cfg_data[0];
        CFG_TIMEOUT:     rtt_estimate   <= cfg_data;
        default: ;
      endcase
    end else if (fire) begin
      expected_block      <= expected_block_next;
      last_received_block <= last_received_block_next;
      last_acked_block    <= last_acked_block_next;
      window_count        <= window_count_next;
      byte_total          <= byte_total_next;
      rtt_estimate        <= rtt_estimate_next;
      ack_sent_time       <= ack_sent_time_next;
      wait_active         <= wait_active_next;
      finished            <= finished_next;
    end
  end

endmodule

// File: src/twr_out_reg.sv
// Result register of the windowed TFTP receiver.
// Holds one result until the consumer takes it. Uses twr_pkg.
module twr_out_reg import twr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res_out
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// File: src/tftp_window_receiver.sv
// Top level of the windowed TFTP receiver.
// Depends on twr_pkg, twr_in_reg, twr_step and twr_out_reg.
//
// Usage: each input item is either a received packet header (kind 0) or a
// retry timeout (kind 1), offered on the in_valid/in_ready channel. Every
// item produces exactly one result on the out_valid/out_ready channel,
// carrying the accept, acknowledgement and status decisions and the
// running byte total and round trip estimate.
// Configuration registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. Writes are meant to
// happen only while no item is in flight.
// The item enters the input register, and its result is loaded into the
// result register when that register has space. One item is accepted per
// cycle, limited only by the result register draining.
// When out_ready is low, the result is held and the input register
// still takes one more item if it was empty; then in_ready drops until space frees.
// Synchronous reset empties both registers and restores all registers
// and transfer state to their reset values.
module tftp_window_receiver import twr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [15:0] opcode,
  input  logic [15:0] block_number,
  input  logic [15:0] packet_length,
  input  logic [31:0] now_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accept_data,
  output logic [15:0] payload_bytes,
  output logic        send_ack,
  output logic [15:0] ack_block,
  output logic        restart_wait,
  output logic [1:0]  status,
  output logic [47:0] total_bytes,
  output logic [31:0] round_trip_us,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  event_t  in_item;
  event_t  held_item;
  logic    held_valid;
  logic    space;
  logic    fire;
  result_t step_res;
  result_t out_res;

  assign in_item = '{kind: kind, opcode: opcode, block_number: block_number,
                     packet_length: packet_length, now_us: now_us};
  assign fire      = held_valid && space;
  assign cfg_ready = 1'b1;

  twr_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (fire)
  );

  twr_step u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .ev        (held_item),
    .res       (step_res)
  );

  twr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (step_res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (out_res)
  );

  assign accept_data   = out_res.accept_data;
  assign payload_bytes = out_res.payload_bytes;
  assign send_ack      = out_res.send_ack;
  assign ack_block     = out_res.ack_block;
  assign restart_wait  = out_res.restart_wait;
  assign status        = out_res.status;
  assign total_bytes   = out_res.total_bytes;
  assign round_trip_us = out_res.round_trip_us;

endmodule

// File: verif/twr_decision_checker.sv
`timescale 1ns / 1ps
// Decision checker for the windowed TFTP receiver: watches the item, result and register
// channels, predicts each decision from its own transfer state and compares field by field.
// Depends on twr_pkg.
module twr_decision_checker import twr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        kind,
  input  logic [15:0] opcode,
  input  logic [15:0] block_number,
  input  logic [15:0] packet_length,
  input  logic [31:0] now_us,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        accept_data,
  input  logic [15:0] payload_bytes,
  input  logic        send_ack,
  input  logic [15:0] ack_block,
  input  logic        restart_wait,
  input  logic [1:0]  status,
  input  logic [47:0] total_bytes,
  input  logic [31:0] round_trip_us,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  logic [15:0] blk_size_reg;
  logic [15:0] win_size_reg;
  logic        roll_reg;
  logic [15:0] exp_blk;
  logic [15:0] last_rx_blk;
  logic [15:0] last_ack_blk;
  logic [15:0] win_cnt;
  logic [47:0] bytes_rx;
  logic [31:0] rtt_us;
  logic [31:0] ack_time;
  logic        ack_wait;
  logic        xfer_done;
  result_t     due_decisions[$];
  int          fail_cnt = 0;

  assign mismatches = fail_cnt;

  task automatic report_mismatch(input string msg);
    fail_cnt++;
    if (fail_cnt <= 100) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic predict_decision(input event_t ev, output result_t r);
    logic [15:0] pay;
    logic [48:0] sum;
    logic [31:0] gap_us;
    logic [63:0] avg;
    logic        short_blk;
    r = '0;
    if (xfer_done) begin
    end else if (ev.kind == KIND_TIMEOUT) begin
      r.send_ack = 1'b1;
      r.ack_block = last_ack_blk;
      r.restart_wait = 1'b1;
      ack_time = ev.now_us;
      ack_wait = 1'b1;
    end else if (ev.packet_length < HDR_BYTES) begin
    end else if (ev.opcode == OP_ERROR) begin
      r.status = ST_PEER_ERR;
      xfer_done = 1'b1;
    end else if (ev.opcode != OP_DATA) begin
    end else if (ev.block_number != exp_blk) begin
      r.send_ack = 1'b1;
      r.ack_block = last_rx_blk;
    end else if (ev.packet_length - HDR_BYTES > blk_size_reg) begin
      r.status = ST_OVERSIZE;
      xfer_done = 1'b1;
    end else begin
      pay = ev.packet_length - HDR_BYTES;
      r.accept_data = 1'b1;
      r.payload_bytes = pay;
      sum = {1'b0, bytes_rx} + {33'd0, pay};
      bytes_rx = (sum > {1'b0, MAX48}) ? MAX48 : sum[47:0];
      short_blk = (pay != blk_size_reg);
      win_cnt = win_cnt + 16'd1;
      last_rx_blk = ev.block_number;
      exp_blk = (exp_blk == 16'hFFFF) ? {15'd0, roll_reg} : exp_blk + 16'd1;
      if (short_blk || win_cnt == win_size_reg) begin
        if (ack_wait && ev.now_us >= ack_time) begin
          gap_us = ev.now_us - ack_time;
          avg = (64'(rtt_us) * 64'(RTT_KEEP_WEIGHT) + 64'(gap_us) * 64'(RTT_FRESH_WEIGHT))
                / 64'(RTT_WEIGHT_SCALE);
          rtt_us = (avg > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : avg[31:0];
        end
        last_ack_blk = ev.block_number;
        win_cnt = 16'd0;
        r.send_ack = 1'b1;
        r.ack_block = ev.block_number;
        r.restart_wait = 1'b1;
        ack_time = ev.now_us;
        ack_wait = 1'b1;
        if (short_blk) begin
          r.status = ST_FINISHED;
          xfer_done = 1'b1;
        end
      end
    end
    r.total_bytes = bytes_rx;
    r.round_trip_us = rtt_us;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      blk_size_reg = RST_BLOCK_SIZE;
      win_size_reg = RST_WINDOW_SIZE;
      roll_reg = RST_ROLLOVER;
      exp_blk = 16'd1;
      last_rx_blk = 16'd0;
      last_ack_blk = 16'd0;
      win_cnt = 16'd0;
      bytes_rx = 48'd0;
      rtt_us = RST_TIMEOUT;
      ack_time = 32'd0;
      ack_wait = 1'b0;
      xfer_done = 1'b0;
      due_decisions.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {accept_data, payload_bytes, send_ack, ack_block, restart_wait, status,
               total_bytes, round_trip_us};
        if (due_decisions.size() == 0) begin
          report_mismatch("result arrived with no item waiting for it");
        end else begin
          want = due_decisions.pop_front();
          cmp_field("accept_data", got.accept_data, want.accept_data);
          cmp_field("payload_bytes", got.payload_bytes, want.payload_bytes);
          cmp_field("send_ack", got.send_ack, want.send_ack);
          cmp_field("ack_block", got.ack_block, want.ack_block);
          cmp_field("restart_wait", got.restart_wait, want.restart_wait);
          cmp_field("status", got.status, want.status);
          cmp_field("total_bytes", got.total_bytes, want.total_bytes);
          cmp_field("round_trip_us", got.round_trip_us, want.round_trip_us);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLOCK_SIZE:  blk_size_reg = cfg_data[15:0];
          CFG_WINDOW_SIZE: win_size_reg = cfg_data[15:0];
          CFG_ROLLOVER:    roll_reg = cfg_data[0];
          CFG_TIMEOUT:     rtt_us = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        predict_decision({kind, opcode, block_number, packet_length, now_us}, want);
        due_decisions.push_back(want);
      end
      outstanding <= due_decisions.size();
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for the windowed TFTP receiver: drives packet and timeout items, register
// writes and output stalls, and gives the verdict. Depends on twr_pkg, tftp_window_receiver
// and twr_decision_checker.
module tb;
  import twr_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 4000;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = KIND_PACKET;
  logic [15:0] opcode = 16'd0;
  logic [15:0] block_number = 16'd0;
  logic [15:0] packet_length = 16'd0;
  logic [31:0] now_us = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        accept_data;
  logic [15:0] payload_bytes;
  logic        send_ack;
  logic [15:0] ack_block;
  logic        restart_wait;
  logic [1:0]  status;
  logic [47:0] total_bytes;
  logic [31:0] round_trip_us;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_BLOCK_SIZE;
  logic [31:0] cfg_data = 32'd0;
  int          mismatches;
  int          outstanding;

  logic [15:0] blk_size = RST_BLOCK_SIZE;
  logic        roll = RST_ROLLOVER;
  logic [15:0] nxt_blk = 16'd1;
  logic [31:0] t_now = 32'd0;
  bit          quiet = 1'b0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          rx_gap = 0;
  int          idle_cycles = 0;

  tftp_window_receiver DUT (.*);

  twr_decision_checker CHK (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] tick();
    if ($urandom_range(0, 39) == 0) begin
      t_now = $urandom;
    end else begin
      t_now = t_now + $urandom_range(1, 3000);
    end
    return t_now;
  endfunction

  function automatic logic [15:0] next_of(input logic [15:0] b);
    return (b == 16'hFFFF) ? {15'd0, roll} : b + 16'd1;
  endfunction

  function automatic event_t make_item(input logic k, input logic [15:0] op,
                                       input logic [15:0] blk, input logic [15:0] len,
                                       input logic [31:0] t);
    event_t ev;
    ev.kind = k;
    ev.opcode = op;
    ev.block_number = blk;
    ev.packet_length = len;
    ev.now_us = t;
    return ev;
  endfunction

  // Valid stays high from one item to the next when there is no gap between them.
  task automatic send_item(input event_t ev);
    int gap;
    gap = quiet ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= ev.kind;
    opcode <= ev.opcode;
    block_number <= ev.block_number;
    packet_length <= ev.packet_length;
    now_us <= ev.now_us;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_block();
    send_item(make_item(KIND_PACKET, OP_DATA, nxt_blk, blk_size + HDR_BYTES, tick()));
    nxt_blk = next_of(nxt_blk);
  endtask

  // Random packets and timeouts that never end the transfer.
  task automatic send_noise();
    event_t ev;
    int r;
    ev.kind = ($urandom_range(0, 3) == 0) ? KIND_TIMEOUT : KIND_PACKET;
    r = $urandom_range(0, 9);
    ev.opcode = (r < 5) ? OP_DATA : (r < 7) ? OP_ERROR : 16'($urandom);
    ev.block_number = ($urandom_range(0, 1) == 0) ?
                      nxt_blk + 16'($urandom_range(0, 4)) - 16'd2 : 16'($urandom);
    r = $urandom_range(0, 9);
    ev.packet_length = (r < 3) ? 16'($urandom_range(0, 3)) :
                       (r < 6) ? blk_size + 16'($urandom_range(0, 8)) : 16'($urandom);
    ev.now_us = tick();
    if (ev.kind == KIND_PACKET && ev.packet_length >= HDR_BYTES) begin
      if (ev.opcode == OP_ERROR) begin
        ev.packet_length = 16'($urandom_range(0, 3));
      end else if (ev.opcode == OP_DATA && ev.block_number == nxt_blk) begin
        ev.packet_length = blk_size + HDR_BYTES;
      end
    end
    send_item(ev);
    if (ev.kind == KIND_PACKET && ev.opcode == OP_DATA && ev.block_number == nxt_blk &&
        ev.packet_length >= HDR_BYTES) begin
      nxt_blk = next_of(nxt_blk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
      hold_seen <= 0;
    end else if (rx_gap != 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (hold_seen != hold_req) begin
      out_ready <= 1'b0;
      rx_gap <= HOLD_CYCLES;
      hold_seen <= hold_req;
    end else begin
      out_ready <= 1'b1;
      rx_gap <= quiet ? 0 : pause_len();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [15:0] bs;
    logic [15:0] ws;
    logic [31:0] tmo;
    logic [1:0]  end_status;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(make_item(KIND_TIMEOUT, 16'd0, 16'd0, 16'd0, 32'd100));
    send_item(make_item(KIND_PACKET, OP_DATA, 16'd1, 16'd0, 32'd150));
    send_item(make_item(KIND_PACKET, OP_DATA, 16'd1, 16'd3, 32'd160));
    send_item(make_item(KIND_PACKET, OP_ERROR, 16'd0, 16'd3, 32'd170));
    send_item(make_item(KIND_PACKET, 16'd4, 16'd1, 16'd516, 32'd180));
    send_item(make_item(KIND_PACKET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd190));
    send_item(make_item(KIND_PACKET, 16'd0, 16'd1, 16'd516, 32'd200));
    send_item(make_item(KIND_PACKET, OP_DATA, 16'd1, 16'd516, 32'd5000));
    send_item(make_item(KIND_PACKET, OP_DATA, 16'd7, 16'd516, 32'd5100));
    send_item(make_item(KIND_PACKET, OP_DATA, 16'd0, 16'hFFFF, 32'd5200));
    send_item(make_item(KIND_PACKET, OP_DATA, 16'hFFFF, 16'd4, 32'd5300));
    send_item(make_item(KIND_PACKET, OP_DATA, 16'd2, 16'd516, 32'd10));
    send_item(make_item(KIND_TIMEOUT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(make_item(KIND_PACKET, OP_DATA, 16'd3, 16'd516, 32'd0));
    send_item(make_item(KIND_PACKET, OP_DATA, 16'd4, 16'd516, 32'hFFFF_FFFF));
    send_item(make_item(KIND_PACKET, OP_DATA, 16'd5, 16'd516, 32'h8000_0000));
    nxt_blk = 16'd6;
    t_now = 32'h8000_0000;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          bs = 16'd8;
          ws = 16'hFFFF;
          tmo = 32'd1;
        end
        1: begin
          bs = 16'd65464;
          ws = 16'($urandom_range(2, 8));
          tmo = 32'hFFFF_FFFF;
        end
        default: begin
          bs = 16'($urandom_range(8, 65464));
          ws = 16'($urandom_range(1, 16));
          tmo = $urandom;
        end
      endcase
      roll = 1'($urandom_range(0, 1));
      blk_size = bs;
      write_reg(CFG_BLOCK_SIZE, {16'($urandom), bs});
      write_reg(CFG_WINDOW_SIZE, {16'($urandom), ws});
      write_reg(CFG_ROLLOVER, {31'($urandom), roll});
      write_reg(CFG_TIMEOUT, tmo);
      for (int n = 0; n < 160; n++) begin
        if (n % 40 == 0) begin
          quiet <= ($urandom_range(0, 3) == 0);
        end
        if (n == 60 && ph < 2) begin
          hold_req <= hold_req + 1;
        end
        if ($urandom_range(0, 4) == 0) begin
          send_noise();
        end else begin
          send_block();
        end
      end
    end

    // Stream full blocks with a window setting of zero, so the window never fills.
    blk_size = 16'd8;
    roll = 1'b1;
    write_reg(CFG_BLOCK_SIZE, 32'd8);
    write_reg(CFG_WINDOW_SIZE, 32'd0);
    write_reg(CFG_ROLLOVER, 32'd1);
    quiet <= 1'b1;
    for (int n = 0; n < 20; n++) begin
      send_block();
    end
    quiet <= 1'b0;
    for (int n = 0; n < 10; n++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_noise();
      end else begin
        send_block();
      end
    end

    end_status = 2'($urandom_range(1, 3));
    case (end_status)
      ST_FINISHED: send_item(make_item(KIND_PACKET, OP_DATA, nxt_blk,
                                       16'($urandom_range(4, blk_size + 3)), tick()));
      ST_PEER_ERR: send_item(make_item(KIND_PACKET, OP_ERROR, 16'($urandom),
                                       16'($urandom_range(4, 65535)), tick()));
      default: send_item(make_item(KIND_PACKET, OP_DATA, nxt_blk,
                                   16'($urandom_range(blk_size + 5, 65535)), tick()));
    endcase
    for (int n = 0; n < 12; n++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_noise();
      end else begin
        send_block();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/twr_pkg.sv
src/twr_in_reg.sv
src/twr_step.sv
src/twr_out_reg.sv
src/tftp_window_receiver.sv
verif/twr_decision_checker.sv
verif/tb.sv
